// ===== rtl/stable_priority_queue_assert.svh =====
// Assertion macros for the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue assertion failed");
`define SPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue assertion failed");
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPQ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   localparam int CUST_W   = 16;
   localparam int TAG_W    = 32;
   localparam int PRIO_W   = 3;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SERVE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [CUST_W-1:0] customer;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic serve;
   } ctrl_type;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell #(
   parameter int PRIORITY_BITS = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::ctrl_type        ctrl,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   input  spq_pkg::entry_type       new_data,
   input  logic                     prev_valid,
   input  logic                     prev_displace,
   input  logic [PRIORITY_BITS-1:0] prev_prio,
   input  spq_pkg::entry_type       prev_data,
   input  logic                     next_valid,
   input  logic [PRIORITY_BITS-1:0] next_prio,
   input  spq_pkg::entry_type       next_data,
   output logic                     valid,
   output logic                     displace,
   output logic [PRIORITY_BITS-1:0] prio,
   output spq_pkg::entry_type       data
);
   import spq_pkg::*;

   logic                     valid_ff, valid_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   entry_type                data_ff, data_in;

   // entry here moves down on insert when it is empty or ranks below the new one
   assign displace = !valid_ff || (prio_ff < new_prio);

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      data_in  = data_ff;
      if (ctrl.insert) begin
         valid_in = valid_ff | prev_valid;
         if (prev_displace) begin
            prio_in = prev_prio;
            data_in = prev_data;
         end else if (displace) begin
            prio_in = new_prio;
            data_in = new_data;
         end
      end else if (ctrl.serve) begin
         valid_in = next_valid;
         prio_in  = next_prio;
         data_in  = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign data  = data_ff;

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue: start with busy low issues one command (insert or
// serve); busy is always low, so a command may be issued every cycle. Each
// command returns one status item on the rsp_ ports, marked by rsp_strobe,
// in the cycle after it was accepted; the receiver cannot stall and must
// take it in that cycle. Storage is a row of QUEUE_DEPTH cells kept sorted
// highest priority first; an insert shifts the tail down one cell and a
// serve shifts all cells up one, both registered when the command is accepted.
// Equal priorities leave in arrival order. A full queue drops inserts and
// reports full; an empty queue reports empty on serve.
`include "stable_priority_queue_assert.svh"

module stable_priority_queue #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int PRIORITY_BITS = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [spq_pkg::CUST_W-1:0]    req_customer_number,
   input  logic [spq_pkg::PRIO_W-1:0]    req_priority_level,
   input  logic [spq_pkg::TAG_W-1:0]     req_order_tag,
   output logic                          rsp_strobe,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_served_valid,
   output logic [spq_pkg::CUST_W-1:0]    rsp_served_customer,
   output logic [spq_pkg::PRIO_W-1:0]    rsp_served_priority,
   output logic [spq_pkg::TAG_W-1:0]     rsp_served_tag,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int OCCX_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;
   localparam int PX_W   = (PRIORITY_BITS > PRIO_W) ? PRIORITY_BITS : PRIO_W;

   logic [CNT_W-1:0] count_ff, count_in;

   logic                     valid_w    [QUEUE_DEPTH];
   logic                     displace_w [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] prio_w     [QUEUE_DEPTH];
   entry_type                data_w     [QUEUE_DEPTH];

   logic                     full, empty, accept;
   ctrl_type                 ctrl;
   logic [PX_W-1:0]          prio_ext;
   logic [PRIORITY_BITS-1:0] new_prio;
   entry_type                new_data;

   logic                  strobe_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  served_ff, served_in;
   logic [CUST_W-1:0]     cust_ff, cust_in;
   logic [PRIO_W-1:0]     sprio_ff, sprio_in;
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic [PX_W-1:0]       head_prio_ext;
   logic [OCCX_W-1:0]     occ_ext;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = valid_w[QUEUE_DEPTH-1];
   assign empty  = !valid_w[0];

   assign ctrl.insert = accept && (req_command == CMD_INSERT) && !full;
   assign ctrl.serve  = accept && (req_command == CMD_SERVE) && !empty;

   assign prio_ext          = PX_W'(req_priority_level);
   assign new_prio          = prio_ext[PRIORITY_BITS-1:0];
   assign new_data.customer = req_customer_number;
   assign new_data.tag      = req_order_tag;

   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic                     pv, pd, nv;
         logic [PRIORITY_BITS-1:0] pp, np;
         entry_type                pdat, ndat;
         if (i == 0) begin : g_head
            assign pv   = 1'b1;
            assign pd   = 1'b0;
            assign pp   = new_prio;
            assign pdat = new_data;
         end else begin : g_body
            assign pv   = valid_w[i-1];
            assign pd   = displace_w[i-1];
            assign pp   = prio_w[i-1];
            assign pdat = data_w[i-1];
         end
         if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign nv   = 1'b0;
            assign np   = prio_w[i];
            assign ndat = data_w[i];
         end else begin : g_mid
            assign nv   = valid_w[i+1];
            assign np   = prio_w[i+1];
            assign ndat = data_w[i+1];
         end
         spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .new_prio     (new_prio),
            .new_data     (new_data),
            .prev_valid   (pv),
            .prev_displace(pd),
            .prev_prio    (pp),
            .prev_data    (pdat),
            .next_valid   (nv),
            .next_prio    (np),
            .next_data    (ndat),
            .valid        (valid_w[i]),
            .displace     (displace_w[i]),
            .prio         (prio_w[i]),
            .data         (data_w[i])
         );
      end
   endgenerate

   assign head_prio_ext = PX_W'(prio_w[0]);

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      served_in = 1'b0;
      cust_in   = '0;
      sprio_in  = '0;
      tag_in    = '0;
      if (req_command == CMD_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            count_in  = count_ff - CNT_W'(1);
            served_in = 1'b1;
            cust_in   = data_w[0].customer;
            sprio_in  = head_prio_ext[PRIO_W-1:0];
            tag_in    = data_w[0].tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         served_ff <= served_in;
         cust_ff   <= cust_in;
         sprio_ff  <= sprio_in;
         tag_ff    <= tag_in;
      end
   end

   assign occ_ext = OCCX_W'(count_ff);

   assign rsp_strobe          = strobe_ff;
   assign rsp_status          = status_ff;
   assign rsp_served_valid    = served_ff;
   assign rsp_served_customer = cust_ff;
   assign rsp_served_priority = sprio_ff;
   assign rsp_served_tag      = tag_ff;
   assign rsp_occupancy       = occ_ext[OCC_W-1:0];

   `SPQ_ASSERT_IMP(a_full_count, clock, reset, 1'b1, (count_ff == CNT_W'(QUEUE_DEPTH)) == full)
   `SPQ_ASSERT_IMP(a_empty_count, clock, reset, 1'b1, (count_ff == '0) == empty)
   `SPQ_ASSERT_NXT(a_insert_grows, clock, reset, ctrl.insert && !reset,
                   count_ff == $past(count_ff) + CNT_W'(1))
   `SPQ_ASSERT_NXT(a_one_result, clock, reset, accept && !reset, rsp_strobe)

endmodule
